// File: sv/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg: shared types and constants for the cluster rank relabel block
// Holds the label and counter widths, the action codes, the beat payload
// structs and the memory port structs used between the modules.
// ----------------------------------------------------------------------------
package crr_pkg;

  // Table depth and counter width.
  localparam int MaxClusters = 64;
  localparam int CountBits   = 32;

  // Label index width and a width that can also hold the depth itself.
  localparam int IdxW = $clog2(MaxClusters);
  localparam int NumW = $clog2(MaxClusters + 1);

  // Width of the cluster_count register.
  localparam int CfgW = 7;

  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [NumW-1:0]      num_t;
  typedef logic [CountBits-1:0] count_t;

  // Action codes carried by an input beat.
  typedef enum logic [1:0] {
    ActClear = 2'd0,
    ActCount = 2'd1,
    ActRank  = 2'd2,
    ActXlate = 2'd3
  } action_e;

  // Input beat payload.
  typedef struct packed {
    action_e    action;
    logic [5:0] label;
  } crr_in_t;

  // Output beat payload.
  typedef struct packed {
    logic [5:0] new_label;
    logic       label_bad;
  } crr_out_t;

  // Read request into a memory.
  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_req_t;

  // Write request into the rank table.
  typedef struct packed {
    logic en;
    idx_t addr;
    idx_t data;
  } rank_wr_t;

endpackage

// File: sv/crr_count_mem.sv
// ----------------------------------------------------------------------------
// crr_count_mem: per-label population counters
// One synchronous read port and one write port. A valid bit per entry gives
// a clear of all entries at once; an entry that is not valid reads as zero. A write or a
// clear in the same cycle as a read is forwarded into the read data.
// ----------------------------------------------------------------------------
module crr_count_mem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  crr_pkg::rd_req_t rd_i,
  output crr_pkg::count_t  rd_data_o,
  input  logic             wr_en_i,
  input  crr_pkg::idx_t    wr_addr_i,
  input  crr_pkg::count_t  wr_data_i
);
  import crr_pkg::*;

  count_t                 mem_q [MaxClusters];
  logic [MaxClusters-1:0] vld_q;
  count_t                 rd_data_q;

  // Counter storage.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Valid bits: cleared all at once, set on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read with forwarding of a same-cycle clear or write.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      if (clear_i) begin
        rd_data_q <= '0;
      end else if (wr_en_i && (wr_addr_i == rd_i.addr)) begin
        rd_data_q <= wr_data_i;
      end else if (vld_q[rd_i.addr]) begin
        rd_data_q <= mem_q[rd_i.addr];
      end else begin
        rd_data_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/crr_rank_mem.sv
// ----------------------------------------------------------------------------
// crr_rank_mem: label to rank table
// One synchronous read port and one write port. An entry that has never been
// written reads as its own address, which is the identity mapping.
// ----------------------------------------------------------------------------
module crr_rank_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crr_pkg::rd_req_t  rd_i,
  output crr_pkg::idx_t     rd_data_o,
  input  crr_pkg::rank_wr_t wr_i
);
  import crr_pkg::*;

  idx_t                   mem_q [MaxClusters];
  logic [MaxClusters-1:0] vld_q;
  idx_t                   rd_data_q;

  // Rank storage.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Valid bits mark entries that hold a written rank.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // Registered read, with a same-cycle write forwarded.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      if (wr_i.en && (wr_i.addr == rd_i.addr)) begin
        rd_data_q <= wr_i.data;
      end else if (vld_q[rd_i.addr]) begin
        rd_data_q <= mem_q[rd_i.addr];
      end else begin
        rd_data_q <= rd_i.addr;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/crr_sort.sv
// ----------------------------------------------------------------------------
// crr_sort: selection sort sequencer
// Copies the first n counters into a work memory of (label, count) pairs,
// then for each position scans the rest for the first strictly greatest
// count, swaps it into place and writes the rank of the chosen label.
// ----------------------------------------------------------------------------
module crr_sort (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  crr_pkg::num_t     num_i,
  output crr_pkg::rd_req_t  cnt_rd_o,
  input  crr_pkg::count_t   cnt_rd_data_i,
  output crr_pkg::rank_wr_t rank_wr_o,
  output logic              busy_o
);
  import crr_pkg::*;

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SLoad  = 5'b00010,
    SScan  = 5'b00100,
    SSwapA = 5'b01000,
    SSwapB = 5'b10000
  } sort_state_e;

  typedef struct packed {
    idx_t   label;
    count_t count;
  } work_t;

  sort_state_e state_q, state_d;
  num_t        n_q, n_d;
  num_t        i_q, i_d;
  num_t        j_q, j_d;
  logic        pend_q, pend_d;
  idx_t        pos_q, pos_d;
  work_t       best_q, best_d;
  idx_t        bpos_q, bpos_d;
  work_t       ent_q, ent_d;

  // Work memory ports.
  work_t       wk_mem_q [MaxClusters];
  work_t       wk_rd_q;
  logic        wk_re, wk_we;
  idx_t        wk_raddr, wk_waddr;
  work_t       wk_wdata;
  logic        issue;
  num_t        i_inc;

  // Sequencer next-state logic.
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    i_d       = i_q;
    j_d       = j_q;
    pend_d    = 1'b0;
    pos_d     = pos_q;
    best_d    = best_q;
    bpos_d    = bpos_q;
    ent_d     = ent_q;
    wk_re     = 1'b0;
    wk_we     = 1'b0;
    wk_raddr  = j_q[IdxW-1:0];
    wk_waddr  = pos_q;
    wk_wdata  = '{label: pos_q, count: cnt_rd_data_i};
    cnt_rd_o  = '{en: 1'b0, addr: j_q[IdxW-1:0]};
    rank_wr_o = '{en: 1'b0, addr: best_q.label, data: i_q[IdxW-1:0]};
    issue     = (j_q < n_q);
    i_inc     = i_q + NumW'(1);

    case (state_q)
      SIdle: begin
        if (start_i && (num_i != '0)) begin
          state_d = SLoad;
          n_d     = num_i;
          j_d     = '0;
        end
      end

      // Copy counter j into work entry j, one read a cycle.
      SLoad: begin
        cnt_rd_o.en = issue;
        if (issue) begin
          j_d = j_q + NumW'(1);
        end
        pend_d = issue;
        pos_d  = j_q[IdxW-1:0];
        wk_we  = pend_q;
        if (!issue && !pend_q) begin
          state_d = SScan;
          i_d     = '0;
          j_d     = '0;
        end
      end

      // Walk positions i..n-1 and keep the first strictly greatest count.
      SScan: begin
        wk_re = issue;
        if (issue) begin
          j_d = j_q + NumW'(1);
        end
        pend_d = issue;
        pos_d  = j_q[IdxW-1:0];
        if (pend_q) begin
          if (pos_q == i_q[IdxW-1:0]) begin
            ent_d  = wk_rd_q;
            best_d = wk_rd_q;
            bpos_d = pos_q;
          end else if (wk_rd_q.count > best_q.count) begin
            best_d = wk_rd_q;
            bpos_d = pos_q;
          end
        end
        if (!issue && !pend_q) begin
          state_d = SSwapA;
        end
      end

      // Position i is final: store the winner there and record its rank.
      SSwapA: begin
        wk_we        = 1'b1;
        wk_waddr     = i_q[IdxW-1:0];
        wk_wdata     = best_q;
        rank_wr_o.en = 1'b1;
        state_d      = SSwapB;
      end

      // Move the displaced entry into the winner's old slot.
      SSwapB: begin
        wk_we    = 1'b1;
        wk_waddr = bpos_q;
        wk_wdata = ent_q;
        i_d      = i_inc;
        j_d      = i_inc;
        if (i_inc == n_q) begin
          state_d = SIdle;
        end else begin
          state_d = SScan;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    best_q <= best_d;
    bpos_q <= bpos_d;
    ent_q  <= ent_d;
  end

  // Work memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      wk_mem_q[wk_waddr] <= wk_wdata;
    end
    if (wk_re) begin
      wk_rd_q <= wk_mem_q[wk_raddr];
    end
  end

  assign busy_o = (state_q != SIdle);

endmodule

// File: sv/cluster_rank_relabel_top.sv
// ----------------------------------------------------------------------------
// cluster_rank_relabel_top: frequency rank relabeling of cluster labels
// Counts labels, ranks them by descending population and translates a
// label to its rank.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  in_data_i   (crr_in_t)
//   out      output     out_valid_o/ out_ready_i out_data_o  (crr_out_t)
//   cfg      input      cfg_we_i                 cfg_wdata_i (cluster_count)
//
// Clear, count and translate beats are taken one per cycle while the output
// is not stalled; a beat reads the counter or rank memory at acceptance and
// finishes in the stage register after it, with a same-label count forwarded.
// A rank beat holds the input while the selection sort ranks the n clamped
// labels, scanning its work memory one entry a cycle. Clear empties every
// counter at once and reset needs no clearing pass. A stalled output holds
// at most one result in the output register and one behind it.
// ----------------------------------------------------------------------------
module cluster_rank_relabel_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  crr_pkg::crr_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output crr_pkg::crr_out_t        out_data_o,
  input  logic                     cfg_we_i,
  input  logic [crr_pkg::CfgW-1:0] cfg_wdata_i
);
  import crr_pkg::*;

  logic [CfgW-1:0] cluster_count_q;
  num_t            n_eff;
  logic            in_bad;
  logic            accept;

  // Stage after acceptance.
  logic            s1_valid_q;
  action_e         s1_action_q;
  idx_t            s1_label_q;
  logic            s1_bad_q;
  logic            s1_result;
  logic            s1_adv;

  // Output register.
  logic            out_valid_q;
  crr_out_t        out_data_q;
  crr_out_t        result;
  logic            out_free;

  // Memory and sequencer connections.
  rd_req_t         cnt_rd, sort_cnt_rd;
  count_t          cnt_rd_data;
  logic            cnt_clear;
  logic            cnt_we;
  count_t          cnt_wdata;
  rd_req_t         rank_rd;
  idx_t            rank_rd_data;
  rank_wr_t        rank_wr;
  logic            sort_start;
  logic            sort_busy;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q <= CfgW'(5);
    end else if (cfg_we_i) begin
      cluster_count_q <= cfg_wdata_i;
    end
  end

  // Clamp the label count to the table depth and check the label.
  assign n_eff  = (NumW'(cluster_count_q) > NumW'(MaxClusters)) ? NumW'(MaxClusters)
                                                                : NumW'(cluster_count_q);
  assign in_bad = (NumW'(in_data_i.label) >= n_eff);

  // Stage handshake: a beat with a result waits for the output register.
  assign s1_result = s1_valid_q &&
                     ((s1_action_q == ActXlate) || ((s1_action_q == ActCount) && s1_bad_q));
  assign out_free  = !out_valid_q || out_ready_i;
  assign s1_adv    = !s1_result || out_free;
  assign in_ready_o = !sort_busy && !(s1_valid_q && (s1_action_q == ActRank)) &&
                      (!s1_valid_q || s1_adv);
  assign accept    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= in_data_i.action;
      s1_label_q  <= IdxW'(in_data_i.label);
      s1_bad_q    <= in_bad;
    end
  end

  // Counter read at acceptance, saturating increment in the next cycle.
  assign cnt_rd    = sort_cnt_rd.en ? sort_cnt_rd
                                    : rd_req_t'{en: accept, addr: IdxW'(in_data_i.label)};
  assign cnt_clear = s1_valid_q && (s1_action_q == ActClear);
  assign cnt_we    = s1_valid_q && (s1_action_q == ActCount) && !s1_bad_q;
  assign cnt_wdata = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + CountBits'(1);

  crr_count_mem u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cnt_clear),
    .rd_i      (cnt_rd),
    .rd_data_o (cnt_rd_data),
    .wr_en_i   (cnt_we),
    .wr_addr_i (s1_label_q),
    .wr_data_i (cnt_wdata)
  );

  // Rank table read for translate beats.
  assign rank_rd = '{en: accept, addr: IdxW'(in_data_i.label)};

  crr_rank_mem u_rank_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rank_rd),
    .rd_data_o (rank_rd_data),
    .wr_i      (rank_wr)
  );

  // Sort sequencer starts once the rank beat leaves the stage.
  assign sort_start = s1_valid_q && (s1_action_q == ActRank);

  crr_sort u_sort (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (sort_start),
    .num_i         (n_eff),
    .cnt_rd_o      (sort_cnt_rd),
    .cnt_rd_data_i (cnt_rd_data),
    .rank_wr_o     (rank_wr),
    .busy_o        (sort_busy)
  );

  // Result beat: a bad label gives rank zero with the flag set.
  always_comb begin
    result.label_bad = s1_bad_q;
    result.new_label = s1_bad_q ? 6'd0 : 6'(rank_rd_data);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_result && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_result && out_free) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: dv/tb_cluster_rank_relabel_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cluster_rank_relabel_top: self-checking bench for the rank relabel block
// Drives clear, count, rank and translate beats with random idles on both
// channels and a range of cluster_count settings. It predicts every result
// from its own copy of the counters and rank table, and checks each output
// beat field by field in order.
// ----------------------------------------------------------------------------
module tb_cluster_rank_relabel_top;
  import crr_pkg::*;

  // Predicts results from a private copy of the label counters and ranks.
  class relabel_scoreboard;
    count_t          pop_count [MaxClusters];
    idx_t            rank_of   [MaxClusters];
    logic [CfgW-1:0] cluster_count;
    crr_out_t        pending_q [$];
    int unsigned     errors;
    int unsigned     results_checked;
    int unsigned     ranks_seen;
    int unsigned     xlates_seen;
    int unsigned     bad_seen;

    function new();
      cluster_count = 7'd5;
      for (int i = 0; i < MaxClusters; i++) begin
        pop_count[i] = '0;
        rank_of[i]   = idx_t'(i);
      end
    endfunction

    function void set_cluster_count(logic [CfgW-1:0] value);
      cluster_count = value;
    endfunction

    // Labels in use: the register clamped to the table depth.
    function int unsigned active_labels();
      return (cluster_count > MaxClusters) ? MaxClusters : int'(cluster_count);
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    // Selection sort by descending count; the first strictly larger entry wins.
    function void rank_by_population();
      idx_t        order [MaxClusters];
      idx_t        tmp;
      int unsigned n;
      int unsigned best;
      n = active_labels();
      for (int i = 0; i < MaxClusters; i++) order[i] = idx_t'(i);
      for (int i = 0; i < n; i++) begin
        best = i;
        for (int j = i + 1; j < n; j++) begin
          if (pop_count[order[j]] > pop_count[order[best]]) best = j;
        end
        tmp         = order[i];
        order[i]    = order[best];
        order[best] = tmp;
      end
      // Entries at or above the active count keep their old rank.
      for (int i = 0; i < n; i++) rank_of[order[i]] = idx_t'(i);
    endfunction

    // Applies one accepted input beat and queues the result it causes.
    function void note_beat(crr_in_t beat);
      crr_out_t    res;
      logic        bad;
      bad = (beat.label >= active_labels());
      res.new_label = '0;
      res.label_bad = 1'b1;
      case (beat.action)
        ActClear: begin
          for (int i = 0; i < MaxClusters; i++) pop_count[i] = '0;
        end
        ActCount: begin
          if (bad) begin
            pending_q.push_back(res);
            bad_seen++;
          end else if (pop_count[beat.label] != '1) begin
            pop_count[beat.label] = pop_count[beat.label] + 1'b1;
          end
        end
        ActRank: begin
          rank_by_population();
          ranks_seen++;
        end
        default: begin
          xlates_seen++;
          if (bad) begin
            bad_seen++;
          end else begin
            res.new_label = rank_of[beat.label];
            res.label_bad = 1'b0;
          end
          pending_q.push_back(res);
        end
      endcase
    endfunction

    task report(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      errors++;
    endtask

    // Compares one output beat with the oldest queued result.
    task check_result(crr_out_t got);
      crr_out_t want;
      results_checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("output beat with nothing queued: new_label %0d label_bad %0d",
                         got.new_label, got.label_bad));
      end else begin
        want = pending_q.pop_front();
        if (got.new_label !== want.new_label)
          report($sformatf("new_label %0d, predicted %0d", got.new_label, want.new_label));
        if (got.label_bad !== want.label_bad)
          report($sformatf("label_bad %0d, predicted %0d", got.label_bad, want.label_bad));
      end
    endtask

    task check_drained();
      if (pending_q.size() != 0)
        report($sformatf("%0d predicted results never arrived", pending_q.size()));
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  crr_in_t         in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  crr_out_t        out_data_o;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  relabel_scoreboard sb = new();
  bit                no_idle = 1'b0;
  int unsigned       beats_sent = 0;
  int unsigned       settings_used = 0;

  cluster_rank_relabel_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Cycles a rank walk may still need after its beat was taken.
  function automatic int unsigned settle_cycles(int unsigned n);
    return n * (n + 1) / 2 + 5 * n + 16;
  endfunction

  // Label picker skewed toward a rotating subset so that counts differ.
  function automatic logic [5:0] pick_label(int unsigned n, int unsigned shift);
    int unsigned a;
    int unsigned b;
    if (n == 0 || $urandom_range(99) < 12) return 6'($urandom_range(63));
    a = $urandom_range(n - 1);
    b = $urandom_range(n - 1);
    return 6'((((a < b) ? a : b) + shift) % n);
  endfunction

  // Presents one input beat, with a random idle first, and waits until taken.
  // Called and returning at a rising edge; valid stays high for a next beat.
  // Ready is sampled at the falling edge, where it holds its value for the
  // next rising edge.
  task automatic send_beat(input action_e act, input logic [5:0] lbl);
    crr_in_t beat;
    bit      taken;
    beat.action = act;
    beat.label  = lbl;
    if (!no_idle) begin
      while ($urandom_range(99) < 27) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (in_ready_o === 1'b1);
      @(posedge clk_i);
    end
    sb.note_beat(beat);
    beats_sent++;
  endtask

  // A run of beats of one action, with some random actions mixed in.
  task automatic send_mixed(input action_e act, input int unsigned beats,
                            input int unsigned shift);
    action_e a;
    for (int k = 0; k < beats; k++) begin
      a = ($urandom_range(99) < 8) ? action_e'($urandom_range(3)) : act;
      send_beat(a, pick_label(sb.active_labels(), shift));
    end
  endtask

  // Stops sending, waits for every queued result, then lets a rank finish.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle_cycles(sb.active_labels())) @(posedge clk_i);
  endtask

  task automatic write_cluster_count(input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_cluster_count(value);
    settings_used++;
  endtask

  // Output side: random stalls, and a check of every beat taken. The
  // handshake and payload are sampled at the falling edge before the edge
  // that takes the beat.
  initial begin : result_sink
    logic     take;
    crr_out_t got;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      take = (out_valid_o === 1'b1) && (out_ready_i === 1'b1);
      got  = out_data_o;
      @(posedge clk_i);
      if (take) sb.check_result(got);
      out_ready_i <= no_idle || ($urandom_range(99) >= 27);
    end
  end

  // Main sequence: directed beats, then random phases per cluster_count.
  initial begin : stimulus
    logic [CfgW-1:0] value;
    int unsigned     phase_end;
    int unsigned     shift;
    bit              first_pause;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    first_pause = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of five labels: identity ranks, bad labels, ties, clear.
    send_beat(ActXlate, 6'd0);
    send_beat(ActXlate, 6'd63);
    send_beat(ActCount, 6'd63);
    send_beat(ActCount, 6'd3);
    send_beat(ActCount, 6'd3);
    send_beat(ActCount, 6'd3);
    send_beat(ActCount, 6'd1);
    send_beat(ActCount, 6'd4);
    send_beat(ActCount, 6'd1);
    send_beat(ActCount, 6'd4);
    send_beat(ActCount, 6'd0);
    send_beat(ActCount, 6'd5);
    send_beat(ActRank, 6'd0);
    for (int i = 0; i <= 5; i++) send_beat(ActXlate, 6'(i));
    send_beat(ActClear, 6'd42);
    send_beat(ActRank, 6'd21);
    send_beat(ActXlate, 6'd3);

    for (int p = 0; p < 9; p++) begin
      drain_and_settle();
      case (p)
        0:       value = 7'd64;
        1:       value = 7'd1;
        2:       value = 7'd0;
        3:       value = 7'd127;
        4:       value = 7'd12;
        5:       value = 7'd2;
        6:       value = 7'($urandom_range(3, 63));
        7:       value = 7'd40;
        default: value = 7'd5;
      endcase
      write_cluster_count(value);
      // One phase runs with both sides always ready.
      no_idle = (p == 3);
      // Translates before any rank see the ranks left from the old setting.
      send_mixed(ActXlate, 4, 0);
      phase_end = beats_sent + 140;
      while (beats_sent < phase_end) begin
        shift = $urandom_range(63);
        if ($urandom_range(3) == 0) send_beat(ActClear, 6'($urandom_range(63)));
        send_mixed(ActCount, $urandom_range(8, 40), shift);
        if (first_pause || $urandom_range(5) == 0) begin
          drain_and_settle();
          first_pause = 1'b0;
        end
        send_beat(ActRank, 6'($urandom_range(63)));
        send_mixed(ActXlate, $urandom_range(6, 20), shift);
      end
    end
    no_idle = 1'b0;

    drain_and_settle();
    sb.check_drained();
    $display("Summary: %0d input beats over %0d cluster_count settings, %0d ranks, %0d translates.",
             beats_sent, settings_used, sb.ranks_seen, sb.xlates_seen);
    $display("Summary: %0d output beats checked, %0d of them flagged as bad labels.",
             sb.results_checked, sb.bad_seen);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #16_000_000;
    $display("TIMEOUT at %0t ns", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: cluster_rank_relabel_top.f
sv/crr_pkg.sv
sv/crr_count_mem.sv
sv/crr_rank_mem.sv
sv/crr_sort.sv
sv/cluster_rank_relabel_top.sv
dv/tb_cluster_rank_relabel_top.sv
